// File: hw/rtl/fpa_pkg.sv
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int NUM_W     = 32 + FRAC_BITS;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_SUB      = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_GT       = 4'd4;
  localparam logic [3:0] OP_LT       = 4'd5;
  localparam logic [3:0] OP_GE       = 4'd6;
  localparam logic [3:0] OP_LE       = 4'd7;
  localparam logic [3:0] OP_EQ       = 4'd8;
  localparam logic [3:0] OP_NE       = 4'd9;
  localparam logic [3:0] OP_MAX      = 4'd10;
  localparam logic [3:0] OP_MIN      = 4'd11;
  localparam logic [3:0] OP_INC      = 4'd12;
  localparam logic [3:0] OP_DEC      = 4'd13;
  localparam logic [3:0] OP_FROM_INT = 4'd14;
  localparam logic [3:0] OP_TO_INT   = 4'd15;

  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_MUL    = 2'd1;
  localparam logic [1:0] KIND_DIV    = 2'd2;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               divide_by_zero;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    in_item_t   item;
  } fq_entry_t;

  typedef struct packed {
    logic       head_valid;
    fq_entry_t  head;
  } fq_head_t;

endpackage

// File: hw/rtl/fpa_front.sv
`timescale 1ns / 1ps
module fpa_front import fpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output fq_head_t  fq_head,
  input  logic      fq_pop
);

  fq_entry_t              mem_r [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]       cnt_r, cnt_nxt;
  logic                   push;
  fq_entry_t              entry;

  // classify by which back-end path the op takes
  always_comb begin
    entry.item = in_item;
    case (in_item.op)
      OP_MUL:  entry.kind = KIND_MUL;
      OP_DIV:  entry.kind = KIND_DIV;
      default: entry.kind = KIND_SIMPLE;
    endcase
  end

  assign in_stall = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign push     = in_valid && !in_stall;

  assign fq_head.head_valid = (cnt_r != '0);
  assign fq_head.head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = fq_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(fq_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |-> cnt_r != '0)
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r == rd_ptr_r + cnt_r[FIFO_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// File: hw/rtl/fpa_back.sv
`timescale 1ns / 1ps
module fpa_back import fpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  fq_head_t  fq_head,
  output logic      fq_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        res;
    logic               cmp;
    logic               dz;
    logic               neg;
    logic signed [63:0] prod;
    logic [31:0]        dvs;
    logic [31:0]        rem;
    logic [NUM_W-1:0]   nq;
  } pipe_t;

  pipe_t           stg_r [0:NUM_W];
  pipe_t           stg_nxt [1:NUM_W];
  pipe_t           s0_nxt;
  logic [NUM_W:0]  vld_r;
  logic            en;
  logic            out_valid_r;
  out_item_t       out_r, out_nxt;

  function automatic pipe_t div_step(pipe_t p);
    pipe_t       s;
    logic [32:0] trial;
    logic        qbit;
    s     = p;
    trial = {p.rem, p.nq[NUM_W-1]};
    if (trial >= {1'b0, p.dvs}) begin
      qbit  = 1'b1;
      s.rem = 32'(trial - {1'b0, p.dvs});
    end else begin
      qbit  = 1'b0;
      s.rem = trial[31:0];
    end
    s.nq = {p.nq[NUM_W-2:0], qbit};
    return s;
  endfunction

  // advance the whole pipe unless a finished item is held at the output
  assign en     = !(out_valid_r && out_stall);
  assign fq_pop = en && fq_head.head_valid;

  always_comb begin
    logic signed [31:0] a, b;
    logic [31:0]        mag_a;
    a = fq_head.head.item.operand_a;
    b = fq_head.head.item.operand_b;
    mag_a = a[31] ? 32'(-a) : 32'(a);
    s0_nxt      = '0;
    s0_nxt.kind = fq_head.head.kind;
    s0_nxt.prod = 64'(a) * 64'(b);
    s0_nxt.dvs  = b[31] ? 32'(-b) : 32'(b);
    s0_nxt.neg  = a[31] ^ b[31];
    s0_nxt.dz   = (fq_head.head.item.op == OP_DIV) && (b == 32'sd0);
    s0_nxt.nq   = {mag_a, {FRAC_BITS{1'b0}}};
    case (fq_head.head.item.op)
      OP_ADD:      s0_nxt.res = 32'(a + b);
      OP_SUB:      s0_nxt.res = 32'(a - b);
      OP_GT:       s0_nxt.cmp = a > b;
      OP_LT:       s0_nxt.cmp = a < b;
      OP_GE:       s0_nxt.cmp = a >= b;
      OP_LE:       s0_nxt.cmp = a <= b;
      OP_EQ:       s0_nxt.cmp = a == b;
      OP_NE:       s0_nxt.cmp = a != b;
      OP_MAX:      s0_nxt.res = (a >= b) ? a : b;
      OP_MIN:      s0_nxt.res = (a <= b) ? a : b;
      OP_INC:      s0_nxt.res = 32'(a + 32'sd1);
      OP_DEC:      s0_nxt.res = 32'(a - 32'sd1);
      OP_FROM_INT: s0_nxt.res = 32'(a <<< FRAC_BITS);
      // bias negatives so the shift truncates toward zero
      OP_TO_INT:   s0_nxt.res = 32'((a + (a[31] ? 32'sd0 + ((32'sd1 <<< FRAC_BITS) - 32'sd1)
                                                  : 32'sd0)) >>> FRAC_BITS);
      default:     s0_nxt.res = '0;
    endcase
  end

  for (genvar g = 1; g <= NUM_W; g++) begin : g_div
    assign stg_nxt[g] = div_step(stg_r[g-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[g] <= stg_nxt[g];
      end
    end
  end

  always_comb begin
    logic signed [63:0] shifted;
    logic [31:0]        q;
    shifted = stg_r[NUM_W].prod >>> FRAC_BITS;
    q       = stg_r[NUM_W].nq[31:0];
    out_nxt.compare_true   = stg_r[NUM_W].cmp;
    out_nxt.divide_by_zero = stg_r[NUM_W].dz;
    case (stg_r[NUM_W].kind)
      KIND_MUL: out_nxt.result_value = shifted[31:0];
      KIND_DIV: begin
        if (stg_r[NUM_W].dz) begin
          out_nxt.result_value = '0;
        end else begin
          out_nxt.result_value = stg_r[NUM_W].neg ? 32'(-q) : q;
        end
      end
      default:  out_nxt.result_value = stg_r[NUM_W].res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0] <= s0_nxt;
      out_r    <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NUM_W-1:0], fq_pop};
      out_valid_r <= vld_r[NUM_W];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.divide_by_zero |-> out_r.result_value == '0)
    else $error("divide by zero with nonzero result");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.divide_by_zero && out_r.compare_true))
    else $error("compare and divide flags both set");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(vld_r))
    else $error("pipe moved while output held");

endmodule

// File: hw/rtl/fixed_point_alu.sv
`timescale 1ns / 1ps
// Path: an accepted item goes from the queue through stage 0, the divider stages and the output register to out_valid.
// Throughput: one item per cycle while out_stall does not hold the output; the divider is one quotient bit per stage.
// A 4-entry queue decouples the input side from the execution pipe.
// Reset: synchronous, active low; clears queue pointers and stage valid bits.
module fixed_point_alu import fpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  fq_head_t fq_head;
  logic     fq_pop;

  fpa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .fq_head  (fq_head),
    .fq_pop   (fq_pop)
  );

  fpa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fq_head   (fq_head),
    .fq_pop    (fq_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
